// File: sv/sw_med_pkg.sv
// Shared widths, defaults and link type for the sliding window median block.
package sw_med_pkg;

    localparam int SAMPLE_W   = 16;  // sample and median width
    localparam int HELD_W     = 5;   // samples_held field width
    localparam int WINDOW_DEF = 16;  // default window depth

    // Link handed from a cell to its right neighbor.
    typedef struct packed {
        logic del_seen;  // the removed entry sits at or left of this cell
        logic gt;        // compacted entry here is greater than the new sample (or empty)
    } t_link;

endpackage

// File: sv/sw_med_if.sv
// Request channel interfaces: sample input and median result output.
interface sw_in_if import sw_med_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sw_out_if import sw_med_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] median;
    logic        [HELD_W-1:0]   samples_held;

    modport source (output valid, output median, output samples_held, input ready);
    modport sink   (input valid, input median, input samples_held, output ready);
endinterface

// File: sv/sw_med_cell.sv
// One cell of the sorted window: holds a sample, its slot tag and a valid bit.
module sw_med_cell import sw_med_pkg::*; #(
    parameter int SLOT_W = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SLOT_W-1:0]   i_wslot,
    input  logic                i_full,
    // right neighbor, raw contents
    input  logic [SAMPLE_W-1:0] i_nxt_value,
    input  logic [SLOT_W-1:0]   i_nxt_slot,
    input  logic                i_nxt_valid,
    input  logic                i_nxt_gt,
    // left neighbor, compacted contents
    input  logic [SAMPLE_W-1:0] i_prv_value,
    input  logic [SLOT_W-1:0]   i_prv_slot,
    input  logic                i_prv_valid,
    input  t_link               i_prv_link,
    // raw contents to the left neighbor
    output logic [SAMPLE_W-1:0] o_value,
    output logic [SLOT_W-1:0]   o_slot,
    output logic                o_valid,
    output logic                o_gt,
    // compacted contents to the right neighbor
    output logic [SAMPLE_W-1:0] o_cc_value,
    output logic [SLOT_W-1:0]   o_cc_slot,
    output logic                o_cc_valid,
    output t_link               o_link
);

    logic [SAMPLE_W-1:0] r_value, n_value;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic                r_valid, n_valid;
    logic                del;

    assign del     = i_full && r_valid && (r_slot == i_wslot);
    assign o_gt    = !r_valid || ($signed(r_value) > $signed(i_sample));
    assign o_value = r_value;
    assign o_slot  = r_slot;
    assign o_valid = r_valid;

    // Close the gap left by the removed entry.
    always_comb begin
        o_link.del_seen = i_prv_link.del_seen || del;
        if (o_link.del_seen) begin
            o_cc_value = i_nxt_value;
            o_cc_slot  = i_nxt_slot;
            o_cc_valid = i_nxt_valid;
            o_link.gt  = i_nxt_gt;
        end else begin
            o_cc_value = r_value;
            o_cc_slot  = r_slot;
            o_cc_valid = r_valid;
            o_link.gt  = o_gt;
        end
    end

    // Open a hole for the new sample where the greater entries begin.
    always_comb begin
        if (i_prv_link.gt) begin
            n_value = i_prv_value;
            n_slot  = i_prv_slot;
            n_valid = i_prv_valid;
        end else if (o_link.gt) begin
            n_value = i_sample;
            n_slot  = i_wslot;
            n_valid = 1'b1;
        end else begin
            n_value = o_cc_value;
            n_slot  = o_cc_slot;
            n_valid = o_cc_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= n_value;
            r_slot  <= n_slot;
        end
    end

endmodule

// File: sv/sliding_window_median_unit.sv
// Top level of the sliding window median: sorted cell row, median readout, output register.
//
// Running median over the last WINDOW signed 16-bit samples.
// Channels: i_in carries one sample per request; o_out returns one result per
// sample: the median of the held samples (mean of the two middles, truncated
// toward zero, when the count is even) and the number held, which saturates
// at WINDOW. Both use valid/ready; a request moves when both are high.
// The sorted row updates in the accept cycle; the two middle entries are then
// read in ST_LO and ST_HI through a single read port over the row, one per
// cycle, and the second read feeds the adder, whose result is registered for
// o_out. A new sample is taken only in the idle state, after that readout.
// Reset empties the window (all cells invalid), clears the write slot and
// count, and drops any pending result. When the receiver stalls, the result
// waits in the output register while the next sample is taken and sorted;
// that sample's readout then waits until the register frees.
module sliding_window_median_unit import sw_med_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sw_in_if.sink    i_in,
    sw_out_if.source o_out
);

    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W = $clog2(WINDOW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a sample
    localparam logic [1:0] ST_LO   = 2'd1;  // reading lower middle
    localparam logic [1:0] ST_HI   = 2'd2;  // reading upper middle, result out

    logic [1:0]         r_state, n_state;
    logic [SLOT_W-1:0]  r_wslot;
    logic [COUNT_W-1:0] r_count;
    logic               accept;
    logic               full;

    logic [SAMPLE_W-1:0] r_lo;
    logic                r_out_valid;
    logic signed [SAMPLE_W-1:0] r_median;
    logic [HELD_W-1:0]   r_held;

    // Cell row wiring; index WINDOW is the empty boundary past the last cell.
    logic [SAMPLE_W-1:0] raw_value [WINDOW+1];
    logic [SLOT_W-1:0]   raw_slot  [WINDOW+1];
    logic                raw_valid [WINDOW+1];
    logic                raw_gt    [WINDOW+1];
    logic [SAMPLE_W-1:0] cc_value  [WINDOW+1];
    logic [SLOT_W-1:0]   cc_slot   [WINDOW+1];
    logic                cc_valid  [WINDOW+1];
    t_link               link      [WINDOW+1];
    logic [WINDOW-1:0]   valid_vec;

    assign accept = i_in.valid && i_in.ready;
    assign full   = (r_count == COUNT_W'(WINDOW));

    // Left boundary: nothing removed, nothing greater.
    assign cc_value[0]  = '0;
    assign cc_slot[0]   = '0;
    assign cc_valid[0]  = 1'b0;
    assign link[0]      = '0;
    // Right boundary: empty cell, reads as greater than anything.
    assign raw_value[WINDOW] = '0;
    assign raw_slot[WINDOW]  = '0;
    assign raw_valid[WINDOW] = 1'b0;
    assign raw_gt[WINDOW]    = 1'b1;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        sw_med_cell #(.SLOT_W(SLOT_W)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (accept),
            .i_sample    (i_in.sample),
            .i_wslot     (r_wslot),
            .i_full      (full),
            .i_nxt_value (raw_value[g+1]),
            .i_nxt_slot  (raw_slot[g+1]),
            .i_nxt_valid (raw_valid[g+1]),
            .i_nxt_gt    (raw_gt[g+1]),
            .i_prv_value (cc_value[g]),
            .i_prv_slot  (cc_slot[g]),
            .i_prv_valid (cc_valid[g]),
            .i_prv_link  (link[g]),
            .o_value     (raw_value[g]),
            .o_slot      (raw_slot[g]),
            .o_valid     (raw_valid[g]),
            .o_gt        (raw_gt[g]),
            .o_cc_value  (cc_value[g+1]),
            .o_cc_slot   (cc_slot[g+1]),
            .o_cc_valid  (cc_valid[g+1]),
            .o_link      (link[g+1])
        );
        assign valid_vec[g] = raw_valid[g];
    end

    // Write slot and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_wslot <= (r_wslot == SLOT_W'(WINDOW - 1)) ? '0 : r_wslot + 1'b1;
            if (!full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Middle readout: lower middle at (n-1)/2, upper at n/2 (same for odd n).
    logic [COUNT_W-1:0]  cnt_m1;
    logic [COUNT_W-1:0]  rd_idx;
    logic [SAMPLE_W-1:0] rd_value;
    logic                out_free;

    assign cnt_m1   = r_count - 1'b1;
    assign rd_idx   = (r_state == ST_LO) ? (cnt_m1 >> 1) : (r_count >> 1);
    assign rd_value = raw_value[rd_idx];
    assign out_free = !r_out_valid || o_out.ready;

    // Sum of the middles, halved toward zero.
    logic signed [SAMPLE_W:0] mid_sum, mid_adj;
    assign mid_sum = $signed({r_lo[SAMPLE_W-1], r_lo}) +
                     $signed({rd_value[SAMPLE_W-1], rd_value});
    assign mid_adj = mid_sum + $signed({{SAMPLE_W{1'b0}}, mid_sum[SAMPLE_W]});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LO;
                end
            end
            ST_LO: begin
                n_state = ST_HI;
            end
            ST_HI: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_HI && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    logic [31:0] held_wide;
    assign held_wide = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LO) begin
            r_lo <= rd_value;
        end
        if (r_state == ST_HI && out_free) begin
            r_median <= mid_adj[SAMPLE_W:1];
            r_held   <= held_wide[HELD_W-1:0];
        end
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.median       = r_median;
    assign o_out.samples_held = r_held;

    // Checks
    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_LO))
        else $error("sample accepted but readout did not start");

    a_cells_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LO) |-> ($countones(valid_vec) == 32'(r_count)))
        else $error("valid cells disagree with fill count");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LO || r_state == ST_HI) |-> (r_count != '0))
        else $error("median readout with an empty window");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= WINDOW)
        else $error("fill count beyond window depth");

endmodule

// File: bench/sliding_window_median_checker.sv
// Scoreboard for the sliding window median: tracks the window, predicts and compares results.
module sliding_window_median_checker import sw_med_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sw_in_if     i_in,
    sw_out_if    i_out,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] median;
        logic        [HELD_W-1:0]   held;
    } t_med_result;

    logic signed [SAMPLE_W-1:0] window_mem [WINDOW];
    int                         write_ptr;
    int                         held_count;
    t_med_result                median_due [$];

    // Insert the new sample, then sort only the written slots.
    function automatic t_med_result running_median(logic signed [SAMPLE_W-1:0] s);
        logic signed [SAMPLE_W-1:0] sorted [WINDOW];
        logic signed [SAMPLE_W-1:0] cur;
        int                         i;
        int                         j;
        int                         pair_sum;
        t_med_result                r;
        window_mem[write_ptr] = s;
        write_ptr = (write_ptr + 1) % WINDOW;
        if (held_count < WINDOW) begin
            held_count++;
        end
        for (i = 0; i < held_count; i++) begin
            cur = window_mem[i];
            j   = i;
            while (j > 0 && sorted[j-1] > cur) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = cur;
        end
        if (held_count % 2 == 1) begin
            r.median = sorted[held_count/2];
        end else begin
            pair_sum = int'(sorted[held_count/2 - 1]) + int'(sorted[held_count/2]);
            r.median = SAMPLE_W'(pair_sum / 2);  // int division truncates toward zero
        end
        r.held = HELD_W'(held_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_med_result want;
        if (!i_rst_n) begin
            write_ptr  = 0;
            held_count = 0;
            median_due.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                median_due.push_back(running_median(i_in.sample));
            end
            if (i_out.valid && i_out.ready) begin
                if (median_due.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("[%0t] unexpected result: median %0d held %0d", $realtime,
                                 i_out.median, i_out.samples_held);
                    end
                    o_fail_count++;
                end else begin
                    want = median_due.pop_front();
                    o_checked++;
                    if (i_out.median !== want.median || i_out.samples_held !== want.held) begin
                        if (o_fail_count < 10) begin
                            $display("[%0t] mismatch: median exp %0d got %0d, held exp %0d got %0d",
                                     $realtime, want.median, i_out.median, want.held,
                                     i_out.samples_held);
                        end
                        o_fail_count++;
                    end
                end
            end
        end
        o_outstanding = median_due.size();
    end

endmodule

// File: bench/sliding_window_median_unit_tb.sv
// Testbench top for the sliding window median unit: clock, reset, stimulus and verdict.
module sliding_window_median_unit_tb import sw_med_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no request on either channel
    localparam int CALM_START     = 2500;   // cycle window with no idling on either side
    localparam int CALM_END       = 4000;
    localparam int TAIL_CYCLES    = 8;      // idle wait after the final drain

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   cycle_count;
    int   idle_cycles;
    int   fail_count;
    int   outstanding;
    int   checked;
    int   directed_sent;
    int   random_sent;

    sw_in_if  in_ch ();
    sw_out_if out_ch ();

    sliding_window_median_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    sliding_window_median_checker scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    // 12 ns period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Cycle counter drives the calm stretch where neither side idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cycle_count <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
        end
    end

    assign calm = (cycle_count >= CALM_START) && (cycle_count < CALM_END);

    // Receiver: stalls about one cycle in five outside the calm stretch.
    always @(negedge i_clk) begin
        out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // Watchdog: a stuck handshake on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles, %0d results pending",
                     idle_cycles, outstanding);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one sample; entered and left at a falling edge. The sender may idle
    // first. valid is set once per step, so back-to-back requests keep it high.
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
        while (!calm && $urandom_range(0, 99) < 20) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.sample <= s;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every expected median has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Random sample, shaped to hit ties, rail values and realistic slow drift
    // as well as full-range noise (every input bit toggles in the noise mode).
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
        logic signed [SAMPLE_W-1:0] last
    );
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            return SAMPLE_W'($urandom);                      // full-range noise
        end else if (mode < 6) begin
            return SAMPLE_W'($urandom_range(0, 8)) - 16'sd4; // narrow band, many ties
        end else if (mode < 7) begin
            case ($urandom_range(0, 3))
                0:       return 16'sh8000;                   // most negative
                1:       return 16'sh7FFF;                   // most positive
                2:       return 16'sh8001;
                default: return 16'sh7FFE;
            endcase
        end else begin
            return last + SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;  // slow drift
        end
    endfunction

    // Directed list. The first sixteen fill the window, so every partial count
    // from one to sixteen shows up; the rest wrap and overwrite the oldest slots.
    //  - rails together: the even-count sum needs 17 bits
    //  - -3 and 0 as middles: halving must truncate toward zero (-1, not -2)
    //  - repeated values: ties in the sort
    localparam int DIRECTED_LEN = 22;
    localparam logic signed [SAMPLE_W-1:0] DIRECTED [DIRECTED_LEN] = '{
        16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000,
        -16'sd3,   16'sd0,    16'sd5,    16'sd5,    16'sd5,    -16'sd1,
        16'sd1,    16'sd0,    16'sh7FFE, 16'sh8001,
        16'sh8000, 16'sd100,  -16'sd100, 16'sd0,    16'sh7FFF, -16'sd3
    };

    initial begin
        int                         k;
        logic signed [SAMPLE_W-1:0] s;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        directed_sent = 0;
        random_sent   = 0;
        s             = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (k = 0; k < DIRECTED_LEN; k++) begin
            send_sample(DIRECTED[k]);
            directed_sent++;
        end
        drain_results();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            // Mid-run pause: sender stops until the pipeline is empty.
            if (k == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            s = pick_sample(s);
            send_sample(s);
            random_sent++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d samples (%0d directed, %0d random), %0d medians compared.",
                 directed_sent + random_sent, directed_sent, random_sent, checked);
        $display("Window fill-up, wraparound, ties, rail values and stalls on both sides.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
